>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge out of reset.
`define LCI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a condition in the next.
`define LCI_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> design/lci_pkg.sv
// ----------------------------------------------------------------------------
// lci_pkg
// Shared types and constants of the linear Cartesian interpolator.
// ----------------------------------------------------------------------------
package lci_pkg;

    localparam int DIST_W = 33;
    localparam int TIME_W = 48;
    localparam int REG_W  = 32;
    localparam int IDX_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // register reset values
    localparam logic [REG_W-1:0] TOL_RST = 32'd66;
    localparam logic [REG_W-1:0] VEL_RST = 32'd6554;
    localparam logic [REG_W-1:0] PER_RST = 32'd655;

    typedef enum logic [IDX_W-1:0] {
        REG_TOL = 2'd0,
        REG_VEL = 2'd1,
        REG_PER = 2'd2
    } t_reg_idx;

    typedef enum logic [STAT_W-1:0] {
        ST_MOVE    = 2'd0,
        ST_RESTART = 2'd1,
        ST_REACHED = 2'd2,
        ST_CLAMP   = 2'd3
    } t_status;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RESTART,
        OP_HOLD,
        OP_MOVE,
        OP_ETA_INIT,
        OP_ETA_STEP,
        OP_SQUARE,
        OP_SQRT_STEP,
        OP_DIST_SAVE,
        OP_DIV_STEP,
        OP_TIME_SAVE,
        OP_LERP,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic in_tol;
        logic eta_full;
        logic out_free;
    } t_stat;

endpackage

>>> design/lci_ctrl.sv
// ----------------------------------------------------------------------------
// lci_ctrl
// Sequencer: steps the datapath through restart, hold or move for one beat.
// ----------------------------------------------------------------------------
module lci_ctrl #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lci_pkg::t_stat i_stat,
    output lci_pkg::t_cmd  o_cmd
);
    import lci_pkg::*;

    localparam int ROOT_W = COORD_WIDTH + 2;
    localparam int DIVD_W = DIST_W + FRACTION_BITS;
    localparam int CNT_N  = (ROOT_W > DIVD_W) ? ROOT_W : DIVD_W;
    localparam int CNT_W  = $clog2(CNT_N);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DECIDE   = 10'b0000000010,
        S_ETA_INIT = 10'b0000000100,
        S_ETA      = 10'b0000001000,
        S_SQUARE   = 10'b0000010000,
        S_SQRT     = 10'b0000100000,
        S_DIST     = 10'b0001000000,
        S_DIV      = 10'b0010000000,
        S_TSAVE    = 10'b0100000000,
        S_OUT      = 10'b1000000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_restart, n_restart;
    logic             r_hold_q, n_hold_q;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and command
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_restart = r_restart;
        o_cmd.op   = OP_NONE;
        o_cmd.axis = 2'(2'd2 - r_cnt[1:0]);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_restart = i_stat.restart;
                if (i_stat.restart) begin
                    o_cmd.op = OP_RESTART;
                    n_cnt    = CNT_W'(2);
                    n_state  = S_SQUARE;
                end else if (i_stat.in_tol) begin
                    o_cmd.op = OP_HOLD;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = OP_MOVE;
                    n_state  = S_ETA_INIT;
                end
            end
            S_ETA_INIT: begin
                o_cmd.op = OP_ETA_INIT;
                if (i_stat.eta_full) begin
                    n_cnt   = CNT_W'(2);
                    n_state = S_SQUARE;
                end else begin
                    n_cnt   = CNT_W'(FRACTION_BITS - 1);
                    n_state = S_ETA;
                end
            end
            S_ETA: begin
                o_cmd.op = OP_ETA_STEP;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_cnt   = CNT_W'(2);
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.op = OP_SQUARE;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_cnt   = CNT_W'(ROOT_W - 1);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT_STEP;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                o_cmd.op = OP_DIST_SAVE;
                if (r_restart) begin
                    n_cnt   = CNT_W'(DIVD_W - 1);
                    n_state = S_DIV;
                end else begin
                    n_cnt   = CNT_W'(2);
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_TSAVE;
                end
            end
            S_TSAVE: begin
                o_cmd.op = OP_TIME_SAVE;
                n_state  = S_OUT;
            end
            S_OUT: begin
                // moving beats run the three lerp steps here before handing off
                if (!r_restart && !r_hold_q && r_cnt <= CNT_W'(2)) begin
                    o_cmd.op = OP_LERP;
                    n_cnt    = (r_cnt == '0) ? CNT_W'(3) : r_cnt - 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold beats skip the lerp steps
    always_comb begin
        n_hold_q = r_hold_q;
        if (r_state == S_DECIDE) begin
            n_hold_q = !i_stat.restart && i_stat.in_tol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_restart <= 1'b0;
            r_hold_q  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_restart <= n_restart;
            r_hold_q  <= n_hold_q;
        end
    end

endmodule

>>> design/lci_datapath.sv
// ----------------------------------------------------------------------------
// lci_datapath
// Position registers, shared multiplier, bit-serial square root and dividers,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module lci_datapath #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16,
    parameter int IN_W          = 192,
    parameter int OUT_W         = 136
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lci_pkg::t_cmd               i_cmd,
    output lci_pkg::t_stat              o_stat,
    input  logic [IN_W-1:0]             i_in_data,
    input  logic                        i_cfg_valid,
    input  logic [lci_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [lci_pkg::REG_W-1:0]   i_cfg_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [OUT_W-1:0]            o_out_data,
    output logic [lci_pkg::STAT_W-1:0]  o_out_user
);
    import lci_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int F      = FRACTION_BITS;
    localparam int MAG_W  = CW + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int RX_W   = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;
    localparam int DIVD_W = DIST_W + F;
    localparam int QX_W   = (DIVD_W > TIME_W) ? DIVD_W : TIME_W;
    localparam int ETA_W  = F + 1;
    localparam logic [SQ_W-1:0]  HALF    = SQ_W'(1) << (F - 1);
    localparam logic [ETA_W-1:0] ETA_ONE = ETA_W'(1) << F;

    // architectural state
    logic                     r_active;
    logic signed [CW-1:0]     r_lgoal [3];
    logic signed [CW-1:0]     r_start [3];
    logic [DIST_W-1:0]        r_dist;
    logic [TIME_W-1:0]        r_total;
    logic [TIME_W-1:0]        r_elapsed;
    logic [REG_W-1:0]         r_tol, r_vel, r_per;

    // working registers
    logic signed [CW-1:0]     r_cur [3];
    logic signed [CW-1:0]     r_goal [3];
    logic signed [CW-1:0]     r_set [3];
    logic [STAT_W-1:0]        r_stat;
    logic [SUM_W-1:0]         r_sum;
    logic [REM_W-1:0]         r_rem;
    logic [ROOT_W-1:0]        r_root;
    logic [REG_W-1:0]         r_drem;
    logic [DIVD_W-1:0]        r_quo;
    logic [TIME_W-1:0]        r_erem;
    logic [ETA_W-1:0]         r_eta;

    // output register
    logic                     r_o_valid;
    logic [OUT_W-1:0]         r_o_data;
    logic [STAT_W-1:0]        r_o_user;

    // axis differences and magnitudes
    logic [MAG_W-1:0] sq_d [3];
    logic [MAG_W-1:0] sq_m [3];
    logic [MAG_W-1:0] ln_d [3];
    logic [MAG_W-1:0] ln_m [3];
    logic             goal_same;

    always_comb begin
        goal_same = 1'b1;
        for (int k = 0; k < 3; k++) begin
            sq_d[k] = {r_goal[k][CW-1], r_goal[k]} - {r_cur[k][CW-1], r_cur[k]};
            sq_m[k] = sq_d[k][MAG_W-1] ? -sq_d[k] : sq_d[k];
            ln_d[k] = {r_goal[k][CW-1], r_goal[k]} - {r_start[k][CW-1], r_start[k]};
            ln_m[k] = ln_d[k][MAG_W-1] ? -ln_d[k] : ln_d[k];
            if (r_goal[k] != r_lgoal[k]) begin
                goal_same = 1'b0;
            end
        end
    end

    // shared multiplier: squares for the norm, magnitude times eta for lerp
    logic [MAG_W-1:0] mul_a, mul_b;
    logic [SQ_W-1:0]  prod;
    logic [SQ_W-1:0]  rnd;
    logic [CW-1:0]    off;
    logic signed [CW-1:0] lerp_set;

    always_comb begin
        if (i_cmd.op == OP_LERP) begin
            mul_a = ln_m[i_cmd.axis];
            mul_b = MAG_W'(r_eta);
        end else begin
            mul_a = sq_m[i_cmd.axis];
            mul_b = sq_m[i_cmd.axis];
        end
        prod     = SQ_W'(mul_a) * SQ_W'(mul_b);
        rnd      = prod + HALF;
        off      = CW'(rnd >> F);
        lerp_set = ln_d[i_cmd.axis][MAG_W-1] ? r_start[i_cmd.axis] - off
                                             : r_start[i_cmd.axis] + off;
    end

    // square root step, two sum bits per step
    logic [REM_W-1:0]  sq_rem2, sq_trial;
    logic              sq_ge;
    logic [RX_W-1:0]   root_x;
    logic [DIST_W-1:0] dist_new;

    always_comb begin
        sq_rem2  = {r_rem[REM_W-3:0], r_sum[SUM_W-1 -: 2]};
        sq_trial = {r_root, 2'b01};
        sq_ge    = (sq_rem2 >= sq_trial);
        root_x   = RX_W'(r_root);
        dist_new = (root_x > RX_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_x);
    end

    // total time division step
    logic [REG_W:0]    dv_rem2;
    logic              dv_ge;
    logic [QX_W-1:0]   quo_x;
    logic [TIME_W-1:0] total_new;

    always_comb begin
        dv_rem2   = {r_drem, r_quo[DIVD_W-1]};
        dv_ge     = (dv_rem2 >= {1'b0, r_vel});
        quo_x     = QX_W'(r_quo);
        if (r_vel == '0 || quo_x > QX_W'(TIME_MAX)) begin
            total_new = TIME_MAX;
        end else begin
            total_new = TIME_W'(quo_x);
        end
    end

    // eta fraction step, elapsed time update
    logic [TIME_W:0] et_rem2;
    logic            et_ge;
    logic [TIME_W:0] el_sum;
    logic            eta_full;

    always_comb begin
        et_rem2  = {r_erem, 1'b0};
        et_ge    = (et_rem2 >= {1'b0, r_total});
        el_sum   = {1'b0, r_elapsed} + (TIME_W + 1)'(r_per);
        eta_full = (r_total == '0) || (r_elapsed >= r_total);
    end

    assign o_stat.restart  = !r_active || !goal_same;
    assign o_stat.in_tol   = (r_dist <= DIST_W'(r_tol));
    assign o_stat.eta_full = eta_full;
    assign o_stat.out_free = !r_o_valid || i_out_ready;

    // state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_dist    <= '0;
            r_total   <= '0;
            r_elapsed <= '0;
            r_tol     <= TOL_RST;
            r_vel     <= VEL_RST;
            r_per     <= PER_RST;
            r_o_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_lgoal[k] <= '0;
                r_start[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_TOL: r_tol <= i_cfg_data;
                    REG_VEL: r_vel <= i_cfg_data;
                    REG_PER: r_per <= i_cfg_data;
                    default: ;
                endcase
            end
            // result beat: load on hand-off, clear when taken
            if (i_cmd.op == OP_OUT) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_RESTART: begin
                    r_active  <= 1'b1;
                    r_elapsed <= '0;
                    for (int k = 0; k < 3; k++) begin
                        r_lgoal[k] <= r_goal[k];
                        r_start[k] <= r_cur[k];
                    end
                end
                OP_HOLD:      r_elapsed <= '0;
                OP_MOVE:      r_elapsed <= el_sum[TIME_W] ? TIME_MAX : el_sum[TIME_W-1:0];
                OP_DIST_SAVE: r_dist    <= dist_new;
                OP_TIME_SAVE: r_total   <= total_new;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                for (int k = 0; k < 3; k++) begin
                    r_cur[k]  <= i_in_data[k*CW +: CW];
                    r_goal[k] <= i_in_data[(3+k)*CW +: CW];
                end
            end
            OP_RESTART: begin
                r_stat <= ST_RESTART;
                for (int k = 0; k < 3; k++) begin
                    r_set[k] <= r_cur[k];
                end
            end
            OP_HOLD: begin
                r_stat <= ST_REACHED;
                for (int k = 0; k < 3; k++) begin
                    r_set[k] <= r_lgoal[k];
                end
            end
            OP_ETA_INIT: begin
                r_erem <= r_elapsed;
                r_eta  <= eta_full ? ETA_ONE : '0;
                r_stat <= (r_total == '0 || r_elapsed > r_total) ? ST_CLAMP : ST_MOVE;
            end
            OP_ETA_STEP: begin
                r_erem <= et_ge ? TIME_W'(et_rem2 - {1'b0, r_total}) : TIME_W'(et_rem2);
                r_eta  <= {r_eta[ETA_W-2:0], et_ge};
            end
            OP_SQUARE: begin
                if (i_cmd.axis == 2'd0) begin
                    r_sum  <= SUM_W'(prod);
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_sum  <= r_sum + SUM_W'(prod);
                end
            end
            OP_SQRT_STEP: begin
                r_sum  <= {r_sum[SUM_W-3:0], 2'b00};
                r_rem  <= sq_ge ? sq_rem2 - sq_trial : sq_rem2;
                r_root <= {r_root[ROOT_W-2:0], sq_ge};
            end
            OP_DIST_SAVE: begin
                r_drem <= '0;
                r_quo  <= {dist_new, F'(0)};
            end
            OP_DIV_STEP: begin
                r_drem <= dv_ge ? REG_W'(dv_rem2 - {1'b0, r_vel}) : REG_W'(dv_rem2);
                r_quo  <= {r_quo[DIVD_W-2:0], dv_ge};
            end
            OP_LERP: begin
                r_set[i_cmd.axis] <= lerp_set;
            end
            OP_OUT: begin
                r_o_data <= OUT_W'({r_dist, r_set[2], r_set[1], r_set[0]});
                r_o_user <= r_stat;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;
    assign o_out_user  = r_o_user;

endmodule

>>> design/linear_cartesian_interpolator_top.sv
// Restart beats run the square root and the one-bit-per-cycle time divider; moving beats
// run the eta fraction steps, skipped when eta is full, then the square root and the lerp
// steps; hold beats skip all of these. One item in flight; the next beat is taken the
// cycle after the result is registered, even while that result waits.
// Synchronous active-low reset clears the move state and loads register defaults.
// ----------------------------------------------------------------------------
// linear_cartesian_interpolator_top
// Straight-line set point interpolation between a latched start and a target.
// ----------------------------------------------------------------------------
module linear_cartesian_interpolator_top #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16,
    parameter int IN_W          = ((6 * COORD_WIDTH + 7) / 8) * 8,
    parameter int OUT_W         = ((3 * COORD_WIDTH + 33 + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // cur_x, cur_y, cur_z, goal_x, goal_y, goal_z
    input  logic [IN_W-1:0]             i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // set_x, set_y, set_z, dist_to_goal
    output logic [OUT_W-1:0]            o_m_axis_tdata,
    // step_status
    output logic [lci_pkg::STAT_W-1:0]  o_m_axis_tuser,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lci_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [lci_pkg::REG_W-1:0]   i_cfg_data
);
    import lci_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    lci_ctrl #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lci_datapath #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .IN_W          (IN_W),
        .OUT_W         (OUT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

endmodule

>>> design/lci_checker.sv
// ----------------------------------------------------------------------------
// lci_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lci_checker #(
    parameter int IN_W  = 192,
    parameter int OUT_W = 136
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic [IN_W-1:0]  i_s_axis_tdata,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    // a stalled result beat keeps its data
    `LCI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result beat dropped or changed while stalled")

    // one item in work at a time
    `LCI_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input taken while an item is in work")

    // a result only appears after the block was busy
    `LCI_ASSERT(a_result_after_work, i_clk, i_rst_n, $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready), "result appeared without work")

endmodule

bind linear_cartesian_interpolator_top lci_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
) u_lci_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the linear Cartesian interpolator against a behavioral predictor.
// Position beats go in with random gaps, set point beats are compared field
// by field, and the registers are rewritten between idle phases.
// ----------------------------------------------------------------------------
module tb;
    import lci_pkg::*;

    localparam int CW    = 32;
    localparam int FB    = 16;
    localparam int IN_W  = ((6 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((3 * CW + 33 + 7) / 8) * 8;
    localparam int N_RANDOM = 1000;

    typedef struct packed {
        logic signed [CW-1:0] gz, gy, gx, cz, cy, cx;
    } t_pos_beat;

    typedef struct {
        logic signed [CW-1:0] sx, sy, sz;
        logic [DIST_W-1:0]    dist_rem;
        t_status              st;
    } t_setpoint;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [IN_W-1:0] i_s_axis_tdata = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic [STAT_W-1:0] o_m_axis_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [REG_W-1:0] i_cfg_data = '0;

    linear_cartesian_interpolator_top DUT (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    bit                   trk_active;
    logic signed [63:0]   trk_goal [3];
    logic signed [63:0]   trk_start [3];
    logic [DIST_W-1:0]    trk_dist;
    logic [TIME_W-1:0]    trk_total;
    logic [TIME_W-1:0]    trk_elapsed;
    logic [REG_W-1:0]     tol_reg = TOL_RST;
    logic [REG_W-1:0]     vel_reg = VEL_RST;
    logic [REG_W-1:0]     per_reg = PER_RST;

    t_pos_beat pending_beats [$];
    t_setpoint expected_points [$];
    int        n_errors;
    int        n_results;
    int        n_status [4];
    bit        stall_busy;
    bit        in_taken;

    function automatic logic [DIST_W-1:0] norm3(logic signed [63:0] a [3],
                                                 logic signed [63:0] b [3]);
        logic [127:0] sum;
        logic [127:0] r;
        logic [63:0]  m;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            m = (b[i] >= a[i]) ? 64'(b[i] - a[i]) : 64'(a[i] - b[i]);
            sum += 128'(m) * 128'(m);
        end
        r = '0;
        for (int bitn = 51; bitn >= 0; bitn--) begin
            if ((r | (128'd1 << bitn)) * (r | (128'd1 << bitn)) <= sum)
                r |= 128'd1 << bitn;
        end
        return (r > 128'(DIST_MAX)) ? DIST_MAX : r[DIST_W-1:0];
    endfunction

    function automatic logic signed [63:0] lerp_axis(logic signed [63:0] s,
            logic signed [63:0] t, logic [63:0] eta);
        logic signed [63:0] d;
        logic [127:0] p;
        logic [63:0] off;
        d = t - s;
        p = 128'((d < 0) ? -d : d) * 128'(eta) + (128'd1 << (FB - 1));
        off = 64'(p >> FB);
        return (d < 0) ? s - $signed(off) : s + $signed(off);
    endfunction

    // advance the predictor by one position beat
    function automatic t_setpoint predict_setpoint(t_pos_beat b);
        t_setpoint r;
        logic signed [63:0] cur [3];
        logic signed [63:0] goal [3];
        logic signed [63:0] set [3];
        logic [127:0] q;
        logic [63:0] eta;
        bit same;
        cur[0] = b.cx; cur[1] = b.cy; cur[2] = b.cz;
        goal[0] = b.gx; goal[1] = b.gy; goal[2] = b.gz;
        same = 1;
        for (int i = 0; i < 3; i++) if (goal[i] != trk_goal[i]) same = 0;
        if (!same || !trk_active) begin
            trk_active = 1;
            trk_goal = goal;
            trk_start = cur;
            set = cur;
            trk_dist = norm3(cur, goal);
            if (vel_reg == 0) trk_total = TIME_MAX;
            else begin
                q = (128'(trk_dist) << FB) / vel_reg;
                trk_total = (q > 128'(TIME_MAX)) ? TIME_MAX : q[TIME_W-1:0];
            end
            trk_elapsed = '0;
            r.st = ST_RESTART;
        end else if (64'(trk_dist) <= 64'(tol_reg)) begin
            trk_elapsed = '0;
            set = trk_goal;
            r.st = ST_REACHED;
        end else begin
            q = 128'(trk_elapsed) + 128'(per_reg);
            trk_elapsed = (q > 128'(TIME_MAX)) ? TIME_MAX : q[TIME_W-1:0];
            r.st = ST_MOVE;
            if (trk_total == 0 || trk_elapsed > trk_total) begin
                eta = 64'd1 << FB;
                r.st = ST_CLAMP;
            end else if (trk_elapsed == trk_total) eta = 64'd1 << FB;
            else eta = 64'((128'(trk_elapsed) << FB) / 128'(trk_total));
            trk_dist = norm3(cur, goal);
            for (int i = 0; i < 3; i++) set[i] = lerp_axis(trk_start[i], goal[i], eta);
        end
        r.sx = set[0][CW-1:0];
        r.sy = set[1][CW-1:0];
        r.sz = set[2][CW-1:0];
        r.dist_rem = trk_dist;
        return r;
    endfunction

    function automatic int rand_gap();
        int k;
        k = $urandom_range(0, 99);
        if (stall_busy) return 0;
        if (k < 55) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // input acceptance, sampled at the rising edge
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (in_taken)
            expected_points.push_back(predict_setpoint(i_s_axis_tdata[6*CW-1:0]));
    end

    // input driver
    int src_gap;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || in_taken) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    i_s_axis_tdata <= IN_W'(pending_beats.pop_front());
                    i_s_axis_tvalid <= 1'b1;
                    src_gap = rand_gap();
                end else i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and ready pattern
    int sink_gap;
    always @(posedge i_clk) begin
        t_setpoint e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            if (expected_points.size() == 0) begin
                $error("set point beat with nothing expected");
                n_errors++;
            end else begin
                e = expected_points.pop_front();
                n_status[e.st]++;
                if (o_m_axis_tdata[CW-1:0] !== e.sx) begin
                    $error("set_x expected %h got %h", e.sx, o_m_axis_tdata[CW-1:0]);
                    n_errors++;
                end
                if (o_m_axis_tdata[2*CW-1:CW] !== e.sy) begin
                    $error("set_y expected %h got %h", e.sy, o_m_axis_tdata[2*CW-1:CW]);
                    n_errors++;
                end
                if (o_m_axis_tdata[3*CW-1:2*CW] !== e.sz) begin
                    $error("set_z expected %h got %h", e.sz, o_m_axis_tdata[3*CW-1:2*CW]);
                    n_errors++;
                end
                if (o_m_axis_tdata[3*CW+DIST_W-1:3*CW] !== e.dist_rem) begin
                    $error("dist_to_goal expected %h got %h", e.dist_rem,
                           o_m_axis_tdata[3*CW+DIST_W-1:3*CW]);
                    n_errors++;
                end
                if (o_m_axis_tuser !== e.st) begin
                    $error("step_status expected %0d got %0d", e.st, o_m_axis_tuser);
                    n_errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (sink_gap > 0) begin
            sink_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            sink_gap = rand_gap();
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [REG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_TOL: tol_reg = val;
            REG_VEL: vel_reg = val;
            default: per_reg = val;
        endcase
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || i_s_axis_tvalid || expected_points.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic drain_wait_partial();
        while (pending_beats.size() > 0) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_coord(int span);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return {1'b0, {(CW-1){1'b1}}};
            default: return CW'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    // a move towards one goal: restart then a run of steps closing in
    task automatic queue_move(int span, int steps);
        t_pos_beat b;
        logic signed [63:0] g [3];
        logic signed [63:0] c [3];
        for (int i = 0; i < 3; i++) begin
            g[i] = $signed(rand_coord(span));
            c[i] = $signed(rand_coord(span));
        end
        for (int s = 0; s <= steps; s++) begin
            b.gx = g[0]; b.gy = g[1]; b.gz = g[2];
            b.cx = CW'(c[0] + (g[0] - c[0]) * s / (steps + 1));
            b.cy = CW'(c[1] + (g[1] - c[1]) * s / (steps + 1));
            b.cz = CW'(c[2] + (g[2] - c[2]) * s / (steps + 1));
            if ($urandom_range(0, 9) == 0) b.cx = $urandom();
            pending_beats.push_back(b);
        end
    endtask

    task automatic queue_directed();
        t_pos_beat b;
        logic [CW-1:0] mn, mx;
        mn = {1'b1, {(CW-1){1'b0}}};
        mx = {1'b0, {(CW-1){1'b1}}};
        // far corners: the largest distances
        b = '{gx: mx, gy: mx, gz: mx, cx: mn, cy: mn, cz: mn};
        repeat (3) pending_beats.push_back(b);
        b = '{gx: mn, gy: mx, gz: mn, cx: mx, cy: mn, cz: mx};
        repeat (2) pending_beats.push_back(b);
        // zero distance: zero total time, then within tolerance
        b = '0;
        repeat (3) pending_beats.push_back(b);
        // all-ones bits in every field
        b = '1;
        repeat (2) pending_beats.push_back(b);
        // short move with several steps
        b = '{gx: 32'h0001_0000, gy: 32'hffff_0000, gz: 32'h0000_8000,
              cx: '0, cy: '0, cz: '0};
        repeat (8) pending_beats.push_back(b);
    endtask

    initial begin
        int n;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        queue_directed();
        drain();
        // register settings: extremes, a fixed setting, then random
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_TOL, 32'd0);
                    write_reg(REG_VEL, 32'hffff_ffff);
                    write_reg(REG_PER, 32'd1);
                end
                1: begin
                    write_reg(REG_TOL, 32'hffff_ffff);
                    write_reg(REG_VEL, 32'd1);
                    write_reg(REG_PER, 32'hffff_ffff);
                end
                2: begin
                    write_reg(REG_TOL, 32'd66);
                    write_reg(REG_VEL, 32'd1 << 20);
                    write_reg(REG_PER, 32'd1 << 14);
                end
                default: begin
                    write_reg(REG_TOL, $urandom_range(0, 1 << 12));
                    write_reg(REG_VEL, $urandom_range(1 << 14, 1 << 24));
                    write_reg(REG_PER, $urandom_range(1 << 10, 1 << 18));
                end
            endcase
            n = 0;
            while (n < N_RANDOM / 6) begin
                if ($urandom_range(0, 9) < 8) begin
                    queue_move($urandom_range(0, 1) ? 32'h4_0000 : 32'h7fff_ffff,
                               $urandom_range(2, 12));
                end else begin
                    pending_beats.push_back({$urandom(), $urandom(), $urandom(),
                                             $urandom(), $urandom(), $urandom()});
                end
                n = pending_beats.size() + n;
                drain_wait_partial();
                n = n - pending_beats.size();
            end
            if (phase == 4) begin
                stall_busy = 1;
                queue_move(32'h4_0000, 20);
                drain();
                stall_busy = 0;
            end
            drain();
        end
        $display("%0d set point beats checked: %0d restart, %0d moving, %0d reached, %0d clamped",
                 n_results, n_status[ST_RESTART], n_status[ST_MOVE],
                 n_status[ST_REACHED], n_status[ST_CLAMP]);
        $display("six register settings including tolerance, velocity and period extremes");
        if (n_errors == 0 && expected_points.size() == 0)
            $display("linear_cartesian_interpolator_top test passed");
        else
            $display("linear_cartesian_interpolator_top test failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("linear_cartesian_interpolator_top test failed");
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/lci_pkg.sv
design/lci_ctrl.sv
design/lci_datapath.sv
design/linear_cartesian_interpolator_top.sv
design/lci_checker.sv
tb/tb.sv
